// ===== rtl/ncs_pkg.sv =====
`default_nettype none
package ncs_pkg;

    localparam int VALUE_W       = 16;
    localparam int ENTRY_W       = 6;
    localparam int COMP_W        = 4;
    localparam int INDEX_W       = 6;
    localparam int DIST_W        = 36;
    localparam int CFG_ENTRIES_W = 7;
    localparam int CFG_LENGTH_W  = 5;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 7;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int MAX_LENGTH_DEF  = 16;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 2'd1;

    localparam logic [CFG_ENTRIES_W-1:0] ENTRIES_RST = 7'd64;
    localparam logic [CFG_LENGTH_W-1:0]  LENGTH_RST  = 5'd16;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef struct packed {
        logic                      op;
        logic [ENTRY_W-1:0]        entry;
        logic [COMP_W-1:0]         component;
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } t_in_item;

    typedef struct packed {
        logic [INDEX_W-1:0] nearest_index;
        logic [DIST_W-1:0]  distance;
    } t_out_item;

    // decoded command handed from front to back
    typedef struct packed {
        logic                      cb_we;
        logic                      q_we;
        logic                      search;
        logic [ENTRY_W-1:0]        entry;
        logic [COMP_W-1:0]         component;
        logic signed [VALUE_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic [CFG_ENTRIES_W-1:0] entries;
        logic [CFG_LENGTH_W-1:0]  length;
    } t_cfg;

    typedef struct packed {
        logic busy;
        logic pipe_active;
    } t_back_stat;

endpackage
`default_nettype wire

// ===== rtl/ncs_ram.sv =====
`default_nettype none
module ncs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/ncs_front.sv =====
`default_nettype none
module ncs_front #(
    parameter int MAX_ENTRIES = ncs_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_LENGTH  = ncs_pkg::MAX_LENGTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire ncs_pkg::t_in_item i_in_item,
    output logic                   o_cmd_valid,
    input  wire logic              i_cmd_pop,
    output ncs_pkg::t_cmd          o_cmd
);

    ncs_pkg::t_cmd r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic [1:0]    n_cnt;
    logic          push;
    logic          ent_ok, comp_ok;
    ncs_pkg::t_cmd cmd;

    // classify: out-of-range indexes write nothing
    always_comb begin
        ent_ok  = 11'(i_in_item.entry) < 11'(MAX_ENTRIES);
        comp_ok = 7'(i_in_item.component) < 7'(MAX_LENGTH);
        cmd.cb_we     = (i_in_item.op == ncs_pkg::OP_LOAD) && ent_ok && comp_ok;
        cmd.q_we      = (i_in_item.op == ncs_pkg::OP_QUERY) && comp_ok;
        cmd.search    = (i_in_item.op == ncs_pkg::OP_QUERY) && i_in_item.last;
        cmd.entry     = i_in_item.entry;
        cmd.component = i_in_item.component;
        cmd.value     = i_in_item.value;
    end

    assign o_in_ready  = (r_cnt != 2'd2);
    assign push        = i_in_valid && o_in_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !i_cmd_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!push && i_cmd_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ncs_back.sv =====
`default_nettype none
module ncs_back #(
    parameter int MAX_ENTRIES = ncs_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_LENGTH  = ncs_pkg::MAX_LENGTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ncs_pkg::t_cfg      i_cfg,
    input  wire logic               i_cmd_valid,
    input  wire ncs_pkg::t_cmd      i_cmd,
    output logic                    o_cmd_pop,
    output logic                    o_res_valid,
    input  wire logic               i_res_ready,
    output ncs_pkg::t_out_item      o_res_item,
    output ncs_pkg::t_back_stat     o_stat
);

    localparam int EW    = $clog2(MAX_ENTRIES);
    localparam int CW    = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int AW    = EW + CW;
    localparam int DEPTH = MAX_ENTRIES * (2 ** CW);
    localparam int VW    = ncs_pkg::VALUE_W;
    localparam int SQW   = 2 * VW;
    localparam int DW    = ncs_pkg::DIST_W;

    // issue side
    logic          r_busy;
    logic [EW-1:0] r_e;
    logic [CW-1:0] r_c;
    logic [EW-1:0] last_e;
    logic [CW-1:0] last_c;

    logic signed [VW-1:0] r_query [MAX_LENGTH];

    // pipeline stages
    logic                 r_v1, r_first1, r_lastc1, r_laste1;
    logic [EW-1:0]        r_e1;
    logic signed [VW-1:0] r_q1;
    logic [VW-1:0]        rdata;

    logic                 r_v2, r_first2, r_lastc2, r_laste2;
    logic [EW-1:0]        r_e2;
    logic [VW-1:0]        r_mag2;

    logic                 r_v3, r_first3, r_lastc3, r_laste3;
    logic [EW-1:0]        r_e3;
    logic [SQW-1:0]       r_sq3;

    logic                 r_v4, r_laste4;
    logic [EW-1:0]        r_e4;
    logic [DW-1:0]        r_acc;

    logic [EW-1:0]        r_best_e;
    logic [DW-1:0]        r_best_d;
    logic                 r_out_valid;
    ncs_pkg::t_out_item   r_out;

    logic                 pipe_active;
    logic                 can_pop;
    logic                 start;
    logic signed [VW:0]   diff;
    logic [DW-1:0]        acc_base;
    logic [DW:0]          acc_sum;
    logic [DW-1:0]        acc_sat;
    logic                 take;
    logic [EW-1:0]        best_e_n;
    logic [DW-1:0]        best_d_n;

    // clamp register counts to 1..max, as last index
    always_comb begin
        if (i_cfg.entries == '0) begin
            last_e = '0;
        end else if (11'(i_cfg.entries) > 11'(MAX_ENTRIES)) begin
            last_e = EW'(MAX_ENTRIES - 1);
        end else begin
            last_e = EW'(i_cfg.entries - 7'd1);
        end
        if (i_cfg.length == '0) begin
            last_c = '0;
        end else if (7'(i_cfg.length) > 7'(MAX_LENGTH)) begin
            last_c = CW'(MAX_LENGTH - 1);
        end else begin
            last_c = CW'(i_cfg.length - 5'd1);
        end
    end

    assign pipe_active = r_v1 || r_v2 || r_v3 || r_v4;
    // a search waits for the pipe to drain and the result slot to empty
    assign can_pop = i_cmd_valid && !r_busy &&
                     (!i_cmd.search || (!pipe_active && !r_out_valid));
    assign start   = can_pop && i_cmd.search;
    assign o_cmd_pop = can_pop;

    ncs_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_codebook (
        .i_clk   (i_clk),
        .i_we    (can_pop && i_cmd.cb_we),
        .i_waddr ({EW'(i_cmd.entry), CW'(i_cmd.component)}),
        .i_wdata (i_cmd.value),
        .i_raddr ({r_e, r_c}),
        .o_rdata (rdata)
    );

    always_comb begin
        diff     = $signed({rdata[VW-1], rdata}) - $signed({r_q1[VW-1], r_q1});
        acc_base = r_first3 ? '0 : r_acc;
        acc_sum  = {1'b0, acc_base} + (DW + 1)'(r_sq3);
        acc_sat  = (acc_sum > {1'b0, ncs_pkg::DIST_MAX}) ? ncs_pkg::DIST_MAX
                                                           : acc_sum[DW-1:0];
        take     = (r_e4 == '0) || (r_acc < r_best_d);
        best_e_n = take ? r_e4 : r_best_e;
        best_d_n = take ? r_acc : r_best_d;
    end

    always_ff @(posedge i_clk) begin
        // payload
        if (can_pop && i_cmd.q_we) begin
            r_query[CW'(i_cmd.component)] <= i_cmd.value;
        end
        r_first1 <= (r_c == '0);
        r_lastc1 <= (r_c == last_c);
        r_laste1 <= (r_e == last_e);
        r_e1     <= r_e;
        r_q1     <= r_query[r_c];

        r_first2 <= r_first1;
        r_lastc2 <= r_lastc1;
        r_laste2 <= r_laste1;
        r_e2     <= r_e1;
        r_mag2   <= diff[VW] ? VW'(-diff) : diff[VW-1:0];

        r_first3 <= r_first2;
        r_lastc3 <= r_lastc2;
        r_laste3 <= r_laste2;
        r_e3     <= r_e2;
        r_sq3    <= SQW'(r_mag2) * SQW'(r_mag2);

        r_laste4 <= r_laste3;
        r_e4     <= r_e3;
        if (r_v3) begin
            r_acc <= acc_sat;
        end
        if (r_v4) begin
            r_best_e <= best_e_n;
            r_best_d <= best_d_n;
        end
        if (r_v4 && r_laste4) begin
            r_out.nearest_index <= ncs_pkg::INDEX_W'(best_e_n);
            r_out.distance      <= best_d_n;
        end

        // control
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_e         <= '0;
            r_c         <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1 <= r_busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3 && r_lastc3;
            if (start) begin
                r_busy <= 1'b1;
                r_e    <= '0;
                r_c    <= '0;
            end else if (r_busy) begin
                if (r_c == last_c) begin
                    r_c <= '0;
                    if (r_e == last_e) begin
                        r_busy <= 1'b0;
                    end else begin
                        r_e <= r_e + EW'(1);
                    end
                end else begin
                    r_c <= r_c + CW'(1);
                end
            end
            if (r_v4 && r_laste4) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res_valid        = r_out_valid;
    assign o_res_item         = r_out;
    assign o_stat.busy        = r_busy;
    assign o_stat.pipe_active = pipe_active;

endmodule
`default_nettype wire

// ===== rtl/nearest_codeword_search.sv =====
`default_nettype none
// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+---------------------------
// in       | input     | i_in_valid / o_in_ready   | i_in_item  (t_in_item)
// res      | output    | o_res_valid / i_res_ready | o_res_item (t_out_item)
// cfg      | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// Load items and query items without last pass through a two-entry command
// queue. A search issues one codebook read per cycle from the single RAM read
// port, one for every component of every entry in use, then drains the pipeline.
// A search starts only when the pipe is drained and the result slot is empty;
// loads keep flowing while a result waits. Reset is synchronous, active low;
// codebook and query contents are not cleared. cfg is always ready.
module nearest_codeword_search #(
    parameter int MAX_ENTRIES = ncs_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_LENGTH  = ncs_pkg::MAX_LENGTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire ncs_pkg::t_in_item                 i_in_item,
    output logic                                   o_res_valid,
    input  wire logic                              i_res_ready,
    output ncs_pkg::t_out_item                     o_res_item,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [ncs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [ncs_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    ncs_pkg::t_cfg       r_cfg;
    ncs_pkg::t_cmd       cmd;
    logic                cmd_valid;
    logic                cmd_pop;
    ncs_pkg::t_back_stat stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.entries <= ncs_pkg::ENTRIES_RST;
            r_cfg.length  <= ncs_pkg::LENGTH_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == ncs_pkg::CFG_ENTRIES) begin
                r_cfg.entries <= i_cfg_data[ncs_pkg::CFG_ENTRIES_W-1:0];
            end else if (i_cfg_index == ncs_pkg::CFG_LENGTH) begin
                r_cfg.length <= i_cfg_data[ncs_pkg::CFG_LENGTH_W-1:0];
            end
        end
    end

    ncs_front #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_LENGTH  (MAX_LENGTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop),
        .o_cmd       (cmd)
    );

    ncs_back #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_LENGTH  (MAX_LENGTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res_item  (o_res_item),
        .o_stat      (stat)
    );

    // a result never coexists with an active scan
    a_busy_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(stat.busy && o_res_valid))
        else $error("result pending while scan active");

    // a result only comes out of the pipeline
    a_result_from_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res_valid) |-> $past(stat.pipe_active))
        else $error("result without pipeline activity");

    // issuing reads always fills the pipeline next cycle
    a_issue_fills_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.busy |=> stat.pipe_active)
        else $error("scan issued nothing into pipeline");

endmodule
`default_nettype wire

// ===== bench/ncs_checker.sv =====
`timescale 1ns / 1ps
module ncs_checker
    import ncs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  t_in_item               i_in_item,
    input  logic                   i_res_valid,
    input  logic                   i_res_ready,
    input  t_out_item              i_res_item,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output int                     o_fail_count,
    output int                     o_matches_due
);

    localparam int BOOK_DEPTH = MAX_ENTRIES_DEF * MAX_LENGTH_DEF;

    logic signed [VALUE_W-1:0] codebook [BOOK_DEPTH];
    logic signed [VALUE_W-1:0] query_vec [MAX_LENGTH_DEF];
    logic [CFG_ENTRIES_W-1:0]  entries_cfg;
    logic [CFG_LENGTH_W-1:0]   length_cfg;
    t_out_item                 pending_matches [$];
    int                        fail_count = 0;

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    function automatic longint sq_distance(input int e, input int len);
        longint sum;
        longint diff;
        sum = 0;
        for (int c = 0; c < len; c++) begin
            diff = longint'(codebook[e * MAX_LENGTH_DEF + c]) - longint'(query_vec[c]);
            sum += diff * diff;
            // hold at the top of the distance range
            if (sum > longint'(DIST_MAX)) return longint'(DIST_MAX);
        end
        return sum;
    endfunction

    function automatic t_out_item find_nearest();
        int        n;
        int        len;
        longint    best_d;
        longint    d;
        t_out_item r;
        n = (entries_cfg == 0) ? 1 :
            (entries_cfg > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : int'(entries_cfg);
        len = (length_cfg == 0) ? 1 :
              (length_cfg > MAX_LENGTH_DEF) ? MAX_LENGTH_DEF : int'(length_cfg);
        best_d = 0;
        r.nearest_index = '0;
        for (int e = 0; e < n; e++) begin
            d = sq_distance(e, len);
            // strict compare keeps the lowest index on a tie
            if (e == 0 || d < best_d) begin
                best_d = d;
                r.nearest_index = e[INDEX_W-1:0];
            end
        end
        r.distance = best_d[DIST_W-1:0];
        return r;
    endfunction

    task automatic absorb_item(input t_in_item it);
        if (it.op == OP_LOAD) begin
            codebook[{it.entry, it.component}] = it.value;
        end else begin
            query_vec[it.component] = it.value;
            if (it.last) pending_matches.push_back(find_nearest());
        end
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (pending_matches.size() == 0) begin
            report_mismatch($sformatf("result index %0d distance %0d with none expected",
                                      got.nearest_index, got.distance));
            return;
        end
        want = pending_matches.pop_front();
        if (got.nearest_index !== want.nearest_index)
            report_mismatch($sformatf("nearest_index %0d, expected %0d",
                                      got.nearest_index, want.nearest_index));
        if (got.distance !== want.distance)
            report_mismatch($sformatf("distance %0d, expected %0d",
                                      got.distance, want.distance));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            entries_cfg = ENTRIES_RST;
            length_cfg  = LENGTH_RST;
            pending_matches.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ENTRIES: entries_cfg = i_cfg_data[CFG_ENTRIES_W-1:0];
                    CFG_LENGTH:  length_cfg  = i_cfg_data[CFG_LENGTH_W-1:0];
                    default: ;
                endcase
            end
            if (i_res_valid && i_res_ready) check_result(i_res_item);
            if (i_in_valid && i_in_ready) absorb_item(i_in_item);
        end
        o_matches_due <= pending_matches.size();
        o_fail_count  <= fail_count;
    end

endmodule

// ===== bench/tb_nearest_codeword_search.sv =====
`timescale 1ns / 1ps
module tb_nearest_codeword_search;
    import ncs_pkg::*;

    localparam int BOOK_DEPTH  = MAX_ENTRIES_DEF * MAX_LENGTH_DEF;
    localparam int SETTLE      = 12;
    localparam int TAIL_CYCLES = 1100;
    localparam int LONG_HOLD   = 1500;
    localparam int QUIET_LIMIT = 20000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_in_item              in_item = '0;
    logic                  res_valid;
    logic                  res_ready = 1'b0;
    t_out_item             res_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    fail_count;
    int                    matches_due;

    bit                    drain_hold_req = 1'b0;
    int                    items_sent = 0;
    int                    burst_left = 0;
    int                    span_entries = MAX_ENTRIES_DEF;
    int                    span_length = MAX_LENGTH_DEF;
    bit                    cb_done [BOOK_DEPTH];
    bit                    q_done [MAX_LENGTH_DEF];
    int                    quiet_cycles = 0;

    nearest_codeword_search DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res_item  (res_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    ncs_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_item     (in_item),
        .i_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .i_res_item    (res_item),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_matches_due (matches_due)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (res_valid && res_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side: stall patterns in segments, plus one long hold on request
    initial begin
        int mode;
        int span;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (drain_hold_req) begin
                res_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                drain_hold_req = 1'b0;
            end else begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(10, 150);
                repeat (span) begin
                    case (mode)
                        0:       res_ready <= 1'b1;
                        1:       res_ready <= ($urandom_range(0, 1) == 1);
                        2:       res_ready <= ($urandom_range(0, 3) == 0);
                        default: res_ready <= ($urandom_range(0, 7) != 0);
                    endcase
                    @(posedge clk);
                    if (drain_hold_req) break;
                end
            end
        end
    end

    function automatic int effective_span(input int raw, input int top);
        if (raw == 0) return 1;
        return (raw > top) ? top : raw;
    endfunction

    function automatic logic [VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'($urandom_range(0, 15));
            3:       return -16'($urandom_range(1, 16));
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic t_in_item make_item(input logic op, input int entry, input int comp,
                                           input logic [VALUE_W-1:0] value, input logic last);
        t_in_item it;
        it.op        = op;
        it.entry     = entry[ENTRY_W-1:0];
        it.component = comp[COMP_W-1:0];
        it.value     = value;
        it.last      = last;
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_item  <= it;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        burst_left--;
        items_sent++;
        if (it.op == OP_LOAD) cb_done[{it.entry, it.component}] = 1'b1;
        else q_done[it.component] = 1'b1;
    endtask

    task automatic wait_idle();
        if (in_valid) in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (matches_due != 0);
        // let trailing loads leave the command queue
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] ent,
                              input logic [CFG_DATA_W-1:0] len, input bit spares);
        wait_idle();
        write_reg(CFG_ENTRIES, ent);
        write_reg(CFG_LENGTH, len);
        if (spares) begin
            write_reg(CFG_SPARE_A, 7'h7F);
            write_reg(CFG_SPARE_B, 7'h2A);
        end
        cfg_valid <= 1'b0;
        span_entries = effective_span(int'(ent[CFG_ENTRIES_W-1:0]), MAX_ENTRIES_DEF);
        span_length  = effective_span(int'(len[CFG_LENGTH_W-1:0]), MAX_LENGTH_DEF);
    endtask

    // write every component that the next search reads and that is still unset
    task automatic fill_missing();
        for (int e = 0; e < span_entries; e++)
            for (int c = 0; c < span_length; c++)
                if (!cb_done[e * MAX_LENGTH_DEF + c])
                    send_item(make_item(OP_LOAD, e, c, rand_value(),
                                        1'($urandom_range(0, 1))));
        for (int c = 0; c < span_length; c++)
            if (!q_done[c])
                send_item(make_item(OP_QUERY, $urandom_range(0, 63), c, rand_value(), 1'b0));
    endtask

    task automatic send_query_vector();
        for (int c = 0; c < span_length; c++) begin
            if (c == span_length - 1) fill_missing();
            send_item(make_item(OP_QUERY, $urandom_range(0, 63), c, rand_value(),
                                c == span_length - 1));
        end
    endtask

    // load one vector into two entries, then search for it exactly
    task automatic send_tie_pair();
        logic [VALUE_W-1:0] vals [MAX_LENGTH_DEF];
        int lo;
        int hi;
        if (span_entries < 2) return;
        lo = $urandom_range(0, span_entries - 2);
        hi = $urandom_range(lo + 1, span_entries - 1);
        for (int c = 0; c < span_length; c++) begin
            vals[c] = rand_value();
            send_item(make_item(OP_LOAD, lo, c, vals[c], 1'b0));
            send_item(make_item(OP_LOAD, hi, c, vals[c], 1'b0));
        end
        for (int c = 0; c < span_length; c++) begin
            if (c == span_length - 1) fill_missing();
            send_item(make_item(OP_QUERY, $urandom_range(0, 63), c, vals[c],
                                c == span_length - 1));
        end
    endtask

    task automatic run_random(input int count);
        int target;
        int pick;
        target = items_sent + count;
        while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                send_query_vector();
            end else if (pick < 65) begin
                repeat ($urandom_range(1, span_length))
                    send_item(make_item(OP_LOAD, $urandom_range(0, span_entries - 1),
                                        $urandom_range(0, span_length - 1), rand_value(),
                                        1'b0));
            end else if (pick < 72) begin
                send_tie_pair();
            end else if (pick < 85) begin
                send_item(make_item(OP_LOAD, $urandom_range(0, 63), $urandom_range(0, 15),
                                    rand_value(), 1'($urandom_range(0, 1))));
            end else if (pick < 93) begin
                send_item(make_item(OP_QUERY, $urandom_range(0, 63), $urandom_range(0, 15),
                                    rand_value(), 1'b0));
            end else begin
                fill_missing();
                send_item(make_item(OP_QUERY, $urandom_range(0, 63), $urandom_range(0, 15),
                                    rand_value(), 1'b1));
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // three entries, two components, unused register indexes too
        set_config(7'd3, 7'd2, 1'b1);
        send_item(make_item(OP_LOAD, 0, 0, 16'h7FFF, 1'b0));
        send_item(make_item(OP_LOAD, 0, 1, 16'h8000, 1'b0));
        send_item(make_item(OP_LOAD, 1, 0, 16'd100, 1'b0));
        send_item(make_item(OP_LOAD, 1, 1, -16'sd100, 1'b0));
        send_item(make_item(OP_LOAD, 2, 0, 16'd100, 1'b0));
        // last on a load must not start a search
        send_item(make_item(OP_LOAD, 2, 1, -16'sd100, 1'b1));
        send_item(make_item(OP_LOAD, 63, 15, 16'h8000, 1'b0));
        // entries one and two tie at zero distance
        send_item(make_item(OP_QUERY, 0, 0, 16'd100, 1'b0));
        send_item(make_item(OP_QUERY, 0, 1, -16'sd100, 1'b1));
        // component beyond the length still searches
        send_item(make_item(OP_QUERY, 63, 15, 16'h0000, 1'b1));
        send_item(make_item(OP_QUERY, 0, 0, 16'h7FFF, 1'b0));
        send_item(make_item(OP_QUERY, 0, 1, 16'h8000, 1'b1));
        send_item(make_item(OP_QUERY, 0, 0, 16'h8000, 1'b0));
        send_item(make_item(OP_QUERY, 63, 1, 16'h7FFF, 1'b1));

        // largest distance: opposite extremes on every component
        set_config(7'd1, 7'd16, 1'b0);
        for (int c = 0; c < MAX_LENGTH_DEF; c++)
            send_item(make_item(OP_LOAD, 0, c, 16'h8000, 1'b0));
        for (int c = 0; c < MAX_LENGTH_DEF; c++)
            send_item(make_item(OP_QUERY, 0, c, 16'h7FFF, c == MAX_LENGTH_DEF - 1));

        // zero registers fall back to one entry and one component
        set_config(7'd0, 7'd0, 1'b0);
        run_random(20);
        // oversized values clamp to the full codebook; the first search loads it all
        set_config(7'd127, 7'd127, 1'b0);
        run_random(30);
        set_config(7'd64, 7'd1, 1'b0);
        run_random(20);
        set_config(7'd2, 7'd16, 1'b0);
        run_random(20);

        // short searches while the result side holds off: fill the block up
        set_config(7'd4, 7'd2, 1'b0);
        drain_hold_req = 1'b1;
        run_random(40);

        repeat (3) begin
            set_config(7'($urandom_range(0, 127)), 7'($urandom_range(0, 31)), 1'b0);
            run_random(15);
        end
        set_config(7'd64, 7'd16, 1'b0);
        run_random(20);

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
